// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the line sensor tracker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, off while reset is asserted
`define LST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent assertion, checked during reset as well
`define LST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/lst_pkg.sv -----
// Package of the line sensor tracker: widths, sensor weights, codes and the
// command, status and configuration structs. No dependencies.
`timescale 1ns / 1ps

package lst_pkg;

  localparam int NumSensors = 8;
  localparam int PosW       = 10;
  localparam int HistDepth  = 5;

  // Divider: magnitude width, divisor width, bits retired per cycle
  localparam int DivW            = 12;
  localparam int OpW             = DivW + 1;
  localparam int DivDenW         = 4;
  localparam int DivBitsPerCycle = 2;
  localparam int DivCycles       = DivW / DivBitsPerCycle;
  localparam int DivCntW         = $clog2(DivCycles + 1);

  localparam logic [DivDenW-1:0] FiltDivisor = DivDenW'(10);

  // Configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam int ConfirmW = 2;
  localparam int GapW     = 4;
  localparam logic [ConfirmW-1:0] ConfirmReset = ConfirmW'(2);
  localparam logic [GapW-1:0]     GapReset     = GapW'(3);

  typedef logic signed [PosW-1:0] pos_t;

  // Sensor weights in thousandths, bit 0 rightmost
  localparam pos_t SensorWeight [NumSensors] = '{
    -10'sd350, -10'sd200, -10'sd120, -10'sd60,
     10'sd60,   10'sd120,  10'sd200,  10'sd350
  };

  typedef enum logic {
    RegConfirm = 1'b0,
    RegGapMin  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ForkNone  = 2'd0,
    ForkLeft  = 2'd1,
    ForkRight = 2'd2,
    ForkCross = 2'd3
  } fork_e;

  typedef enum logic [1:0] {
    CornerStraight = 2'd0,
    CornerLeft     = 2'd1,
    CornerRight    = 2'd2
  } corner_e;

  typedef struct packed {
    logic [ConfirmW-1:0] confirm;
    logic [GapW-1:0]     gap_min;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic cent_start;
    logic push_lost;
    logic push_cent;
    logic filt_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/line_sensor_tracker_top.sv -----
// Line sensor tracker: weighted centroid, history, filter and fork detection.
// Top level; depends on lst_pkg, lst_cfg, lst_ctrl, lst_datapath, lst_div.
//
// Usage:
//   Input channel: sensors_i with in_valid_i / in_stall_o; an item is taken
//   at a clock edge with in_valid_i high and in_stall_o low. Output channel:
//   position_o, lost_line_o, corner_o, fork_type_o, fork120_o with
//   out_valid_o / out_stall_i, one result item per input item.
//   Configuration registers sit on the APB-style port: fork_confirm_count at
//   byte address 0, fork_gap_min at 4. Write them only while the block idles.
//   After accept the controller runs centroid, centroid divide (skipped on
//   a lost line), filter, filter divide and done, then is ready for the next
//   item. The shared two-bits-a-cycle divider is used once for the centroid
//   (only when a sensor is lit) and once for the divide by ten.
//   A finished result waits in the output register while out_stall_i is
//   high; the next item is accepted meanwhile, and its result holds in the
//   datapath until the output register frees.
//   Reset (rst_ni low, asynchronous) clears the history, the last seen
//   position, the fork counter and out_valid_o, and restores register
//   defaults (confirm count 2, gap minimum 3).
`timescale 1ns / 1ps

module line_sensor_tracker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lst_pkg::NumSensors-1:0]     sensors_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lst_pkg::PosW-1:0]    position_o,
  output logic                               lost_line_o,
  output logic [1:0]                         corner_o,
  output logic [1:0]                         fork_type_o,
  output logic                               fork120_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lst_pkg::AddrW-1:0]          paddr,
  input  logic [lst_pkg::DataW-1:0]          pwdata,
  output logic [lst_pkg::DataW-1:0]          prdata,
  output logic                               pready
);

  lst_pkg::cfg_t       cfg;
  lst_pkg::ctrl_cmd_t  cmd;
  lst_pkg::dp_status_t status;

  lst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .sensors_i   (sensors_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .position_o  (position_o),
    .lost_line_o (lost_line_o),
    .corner_o    (corner_o),
    .fork_type_o (fork_type_o),
    .fork120_o   (fork120_o)
  );

endmodule

// ----- hw/rtl/lst_div.sv -----
// Iterative signed divider by a small unsigned divisor, truncating toward zero.
// Restoring scheme, two quotient bits a cycle. Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [lst_pkg::OpW-1:0]     dividend_i,
  input  logic [lst_pkg::DivDenW-1:0]        divisor_i,
  output logic                               done_o,
  output logic signed [lst_pkg::OpW-1:0]     quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [lst_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [lst_pkg::DivW-1:0]          acc_q, acc_d;
  logic [lst_pkg::DivDenW-1:0]       rem_q, rem_d;
  logic [lst_pkg::DivDenW-1:0]       den_q;
  logic                              neg_q;
  logic [lst_pkg::OpW-1:0]           mag;

  assign mag = dividend_i[lst_pkg::OpW-1] ? lst_pkg::OpW'(-dividend_i)
                                          : lst_pkg::OpW'(dividend_i);

  // Retire two quotient bits per cycle
  always_comb begin
    logic [lst_pkg::DivDenW:0]   trial;
    logic [lst_pkg::DivDenW-1:0] rem_v;
    logic [lst_pkg::DivW-1:0]    acc_v;
    rem_v = rem_q;
    acc_v = acc_q;
    for (int k = 0; k < lst_pkg::DivBitsPerCycle; k++) begin
      trial = {rem_v, acc_v[lst_pkg::DivW-1]};
      acc_v = {acc_v[lst_pkg::DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        acc_v[0] = 1'b1;
      end
      rem_v = trial[lst_pkg::DivDenW-1:0];
    end
    rem_d = rem_v;
    acc_d = acc_v;
  end

  // Sequence the iterations
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lst_pkg::DivCntW'(lst_pkg::DivCycles - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands on start, then shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= mag[lst_pkg::DivW-1:0];
      rem_q <= '0;
      den_q <= divisor_i;
      neg_q <= dividend_i[lst_pkg::OpW-1];
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

// ----- hw/rtl/lst_cfg.sv -----
// Configuration registers of the line sensor tracker behind an APB-style port.
// Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lst_pkg::AddrW-1:0]   paddr,
  input  logic [lst_pkg::DataW-1:0]   pwdata,
  output logic [lst_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output lst_pkg::cfg_t               cfg_o
);

  logic [lst_pkg::ConfirmW-1:0] confirm_q;
  logic [lst_pkg::GapW-1:0]     gap_q;
  lst_pkg::reg_idx_e            idx;

  // Word index; byte offset bits are ignored
  assign idx = lst_pkg::reg_idx_e'(paddr[lst_pkg::AddrW-1]);

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= lst_pkg::ConfirmReset;
      gap_q     <= lst_pkg::GapReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        lst_pkg::RegConfirm: confirm_q <= pwdata[lst_pkg::ConfirmW-1:0];
        lst_pkg::RegGapMin:  gap_q     <= pwdata[lst_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      lst_pkg::RegConfirm: prdata = lst_pkg::DataW'(confirm_q);
      lst_pkg::RegGapMin:  prdata = lst_pkg::DataW'(gap_q);
      default:             prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign cfg_o.confirm = confirm_q;
  assign cfg_o.gap_min = gap_q;

endmodule

// ----- hw/rtl/lst_datapath.sv -----
// Datapath of the line sensor tracker: centroid sums, position history, filter,
// corner and fork classification, output register. Depends on lst_pkg, lst_div.
`timescale 1ns / 1ps

module lst_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lst_pkg::ctrl_cmd_t                cmd_i,
  output lst_pkg::dp_status_t               status_o,
  input  lst_pkg::cfg_t                     cfg_i,
  input  logic [lst_pkg::NumSensors-1:0]    sensors_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [lst_pkg::PosW-1:0]   position_o,
  output logic                              lost_line_o,
  output logic [1:0]                        corner_o,
  output logic [1:0]                        fork_type_o,
  output logic                              fork120_o
);

  localparam int MeanW = lst_pkg::PosW + 2;

  logic [lst_pkg::NumSensors-1:0]   sens_q;
  logic signed [lst_pkg::OpW-1:0]   sum_q, sum_in;
  logic [lst_pkg::DivDenW-1:0]      cnt_q, cnt_in;
  lst_pkg::pos_t                    hist_q [lst_pkg::HistDepth];
  lst_pkg::pos_t                    last_q;
  lst_pkg::fork_e                   cand_q;
  logic [1:0]                       stable_q;
  logic                             out_valid_q;
  lst_pkg::pos_t                    pos_q;
  logic                             lost_q;
  lst_pkg::corner_e                 corner_q;
  lst_pkg::fork_e                   fork_q;
  logic                             fork120_q;

  logic signed [MeanW-1:0]          msum;
  logic [MeanW-1:0]                 mbias;
  lst_pkg::pos_t                    mean;
  lst_pkg::pos_t                    lost_pos;
  logic signed [lst_pkg::OpW-1:0]   filt_sum;
  logic                             div_start;
  logic signed [lst_pkg::OpW-1:0]   div_num;
  logic [lst_pkg::DivDenW-1:0]      div_den;
  logic                             div_done;
  logic signed [lst_pkg::OpW-1:0]   quotient;

  lst_pkg::fork_e                   kind;
  logic [1:0]                       stable_new;
  logic                             report;
  lst_pkg::corner_e                 corner_c;
  logic                             fork120_c;

  // Sum weights and count lit sensors of the incoming item
  always_comb begin
    logic signed [lst_pkg::OpW-1:0] sum_v;
    logic [lst_pkg::DivDenW-1:0]    cnt_v;
    sum_v = '0;
    cnt_v = '0;
    for (int i = 0; i < lst_pkg::NumSensors; i++) begin
      if (sensors_i[i]) begin
        sum_v = sum_v + lst_pkg::OpW'(lst_pkg::SensorWeight[i]);
        cnt_v = cnt_v + 1'b1;
      end
    end
    sum_in = sum_v;
    cnt_in = cnt_v;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sens_q <= sensors_i;
      sum_q  <= sum_in;
      cnt_q  <= cnt_in;
    end
  end

  // Mean of the four entries that move to slots one to four, toward zero
  assign msum  = MeanW'(hist_q[0]) + MeanW'(hist_q[1]) +
                 MeanW'(hist_q[2]) + MeanW'(hist_q[3]);
  assign mbias = msum + {{(MeanW-2){1'b0}}, {2{msum[MeanW-1]}}};
  assign mean  = mbias[MeanW-1:2];
  assign lost_pos = (last_q != '0) ? last_q : mean;

  // Filter numerator from the updated history
  assign filt_sum = lst_pkg::OpW'(7) * lst_pkg::OpW'(hist_q[0]) +
                    lst_pkg::OpW'(3) * lst_pkg::OpW'(hist_q[1]);

  // Shared divider: centroid by count, filter by ten
  assign div_start = cmd_i.cent_start | cmd_i.filt_start;
  assign div_num   = cmd_i.filt_start ? filt_sum : sum_q;
  assign div_den   = cmd_i.filt_start ? lst_pkg::FiltDivisor : cnt_q;

  lst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Shift the history and push the new position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lst_pkg::HistDepth; k++) hist_q[k] <= '0;
      last_q <= '0;
    end else if (cmd_i.push_lost || cmd_i.push_cent) begin
      for (int k = 1; k < lst_pkg::HistDepth; k++) hist_q[k] <= hist_q[k-1];
      if (cmd_i.push_cent) begin
        hist_q[0] <= quotient[lst_pkg::PosW-1:0];
        last_q    <= quotient[lst_pkg::PosW-1:0];
      end else begin
        hist_q[0] <= lost_pos;
      end
    end
  end

  // Classify the fork by runs of dark sensors
  always_comb begin
    logic [3:0] cur;
    logic [3:0] longest;
    logic [2:0] runs;
    logic [1:0] low_lit;
    logic [1:0] high_lit;
    cur     = '0;
    longest = '0;
    runs    = '0;
    for (int i = 0; i < lst_pkg::NumSensors; i++) begin
      if (!sens_q[i]) begin
        cur = cur + 4'd1;
      end else if (cur != '0) begin
        runs = runs + 3'd1;
        if (cur > longest) longest = cur;
        cur = '0;
      end
    end
    if (cur != '0) begin
      runs = runs + 3'd1;
      if (cur > longest) longest = cur;
    end
    low_lit  = 2'(sens_q[0]) + 2'(sens_q[1]) + 2'(sens_q[2]);
    high_lit = 2'(sens_q[5]) + 2'(sens_q[6]) + 2'(sens_q[7]);
    if (!(runs >= 3'd2 || longest >= cfg_i.gap_min)) kind = lst_pkg::ForkNone;
    else if (low_lit > high_lit)                    kind = lst_pkg::ForkLeft;
    else if (high_lit > low_lit)                    kind = lst_pkg::ForkRight;
    else                                            kind = lst_pkg::ForkCross;
  end

  // Confirmation counter, saturating at three
  assign stable_new = (kind != cand_q) ? 2'd1 :
                      (stable_q == 2'd3) ? 2'd3 : stable_q + 2'd1;
  assign report     = stable_new >= cfg_i.confirm;

  // Lit segments with a dark center and both sides lit
  always_comb begin
    logic [2:0] segs;
    segs = 3'(sens_q[0]);
    for (int i = 1; i < lst_pkg::NumSensors; i++) begin
      if (sens_q[i] && !sens_q[i-1]) segs = segs + 3'd1;
    end
    fork120_c = (segs >= 3'd2) && !sens_q[3] && !sens_q[4] &&
                (|sens_q[2:0]) && (|sens_q[7:5]);
  end

  always_comb begin
    if (&sens_q[7:5])      corner_c = lst_pkg::CornerLeft;
    else if (&sens_q[2:0]) corner_c = lst_pkg::CornerRight;
    else                   corner_c = lst_pkg::CornerStraight;
  end

  // Commit fork state when the item is handed to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q   <= lst_pkg::ForkNone;
      stable_q <= '0;
    end else if (cmd_i.out_load) begin
      if (kind == lst_pkg::ForkNone || report) begin
        cand_q   <= lst_pkg::ForkNone;
        stable_q <= '0;
      end else begin
        cand_q   <= kind;
        stable_q <= stable_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_q     <= quotient[lst_pkg::PosW-1:0];
      lost_q    <= (cnt_q == '0);
      corner_q  <= corner_c;
      fork_q    <= (kind != lst_pkg::ForkNone && report) ? kind : lst_pkg::ForkNone;
      fork120_q <= fork120_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign lost_line_o = lost_q;
  assign corner_o    = corner_q;
  assign fork_type_o = fork_q;
  assign fork120_o   = fork120_q;

endmodule

// ----- hw/rtl/lst_ctrl.sv -----
// Controller of the line sensor tracker: sequences centroid, history push,
// filter divide and output load. Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lst_pkg::dp_status_t  status_i,
  output lst_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StCent = 6'b000010,
    StCdiv = 6'b000100,
    StFilt = 6'b001000,
    StFdiv = 6'b010000,
    StDone = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCent;
        end
      end
      // Lost line skips the centroid divide
      StCent: begin
        if (status_i.cnt_zero) begin
          cmd_o.push_lost = 1'b1;
          state_d         = StFilt;
        end else begin
          cmd_o.cent_start = 1'b1;
          state_d          = StCdiv;
        end
      end
      StCdiv: begin
        if (status_i.div_done) begin
          cmd_o.push_cent = 1'b1;
          state_d         = StFilt;
        end
      end
      StFilt: begin
        cmd_o.filt_start = 1'b1;
        state_d          = StFdiv;
      end
      StFdiv: begin
        if (status_i.div_done) state_d = StDone;
      end
      // Hold until the output register can take the item
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ----- hw/rtl/lst_checker.sv -----
// Port-level checks of the line sensor tracker, bound to the top level.
// Depends on lst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lst_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic [lst_pkg::NumSensors-1:0]     sensors_i,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [lst_pkg::PosW-1:0]    position_o,
  input  logic                               lost_line_o,
  input  logic [1:0]                         corner_o,
  input  logic [1:0]                         fork_type_o,
  input  logic                               fork120_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lst_pkg::AddrW-1:0]          paddr,
  input  logic [lst_pkg::DataW-1:0]          pwdata,
  input  logic [lst_pkg::DataW-1:0]          prdata,
  input  logic                               pready
);

  // No result is offered while reset is held
  `LST_ASSERT_ALWAYS(a_reset_no_out, !rst_ni |-> !out_valid_o, "out_valid_o high in reset")

  // A stalled result holds its value
  `LST_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(position_o) && $stable(fork_type_o), "stalled result changed")

  // Filtered position stays within the sensor span
  `LST_ASSERT(a_pos_range, out_valid_o |-> position_o >= -10'sd350 && position_o <= 10'sd350, "position out of range")

  // With no lit sensor there is no corner and no 120-degree fork
  `LST_ASSERT(a_lost_flags, out_valid_o && lost_line_o |-> corner_o == lst_pkg::CornerStraight && !fork120_o, "flags set on lost line")

  // One item at a time: the block is busy right after an accept
  `LST_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input taken back to back")

endmodule

bind line_sensor_tracker_top lst_checker u_checker (.*);

// ----- sim/tb_line_sensor_tracker_top.sv -----
// Testbench of line_sensor_tracker_top: a directed table, then bursts of random sensor
// patterns under several register settings, checked against an in-bench tracker model.
// Depends on lst_pkg and the RTL of the line sensor tracker.
`timescale 1ns / 1ps

module tb_line_sensor_tracker_top;
  import lst_pkg::*;

  localparam int NumDirected  = 23;
  localparam int NumPhases    = 10;
  localparam int RandPerPhase = 165;
  localparam int StuckLimit   = 2000;
  localparam int HoldCycles   = 300;
  localparam int TailCycles   = 40;
  localparam int MaxPrinted   = 100;

  typedef struct packed {
    pos_t    position;
    logic    lost;
    corner_e corner;
    fork_e   fork_kind;
    logic    fork120;
  } track_out_t;

  typedef struct packed {
    logic [NumSensors-1:0] sensors;
    logic                  typed;
    track_out_t            want;
  } dir_row_t;

  typedef enum int {
    PatSegment,
    PatTwoSided,
    PatExtreme,
    PatNoise
  } pattern_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [NumSensors-1:0] sensors_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [PosW-1:0] position_o;
  logic                  lost_line_o;
  logic [1:0]            corner_o;
  logic [1:0]            fork_type_o;
  logic                  fork120_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [DataW-1:0]      pwdata;
  logic [DataW-1:0]      prdata;
  logic                  pready;

  // Tracker model state and register copies
  pos_t                hist [HistDepth];
  pos_t                last_seen;
  fork_e               fork_cand;
  logic [1:0]          fork_stable;
  logic [ConfirmW-1:0] cfg_confirm;
  logic [GapW-1:0]     cfg_gap;

  track_out_t expected_q [$];
  track_out_t want_r;
  int         fail_count  = 0;
  int         stuck_cycles = 0;
  int         hold_left   = 0;
  bit         hold_req    = 1'b0;
  bit         quiet       = 1'b0;

  int unsigned phase_confirm [5] = '{0, 3, 1, 3, 0};
  int unsigned phase_gap     [5] = '{0, 15, 8, 9, 1};

  // Directed table, run under the reset register values
  dir_row_t dir_rows [NumDirected] = '{
    '{8'h00, 1'b1, '{10'sd0,    1'b1, CornerStraight, ForkNone,  1'b0}}, // lost after reset
    '{8'hFF, 1'b1, '{10'sd0,    1'b0, CornerLeft,     ForkNone,  1'b0}}, // all lit
    '{8'h01, 1'b0, '0},
    '{8'h01, 1'b1, '{-10'sd350, 1'b0, CornerStraight, ForkLeft,  1'b0}}, // rightmost extreme
    '{8'h80, 1'b0, '0},
    '{8'h80, 1'b1, '{10'sd350,  1'b0, CornerStraight, ForkRight, 1'b0}}, // leftmost extreme
    '{8'h00, 1'b1, '{10'sd350,  1'b1, CornerStraight, ForkNone,  1'b0}}, // hold last seen
    '{8'h00, 1'b1, '{10'sd350,  1'b1, CornerStraight, ForkCross, 1'b0}},
    '{8'h81, 1'b0, '0},  // centroid of zero becomes last seen
    '{8'h00, 1'b0, '0},  // lost with last seen zero: mean of older history
    '{8'h07, 1'b0, '0},
    '{8'hE0, 1'b0, '0},
    '{8'hE7, 1'b0, '0},
    '{8'h18, 1'b0, '0},
    '{8'h0E, 1'b0, '0},  // negative centroid truncates toward zero
    '{8'h70, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h24, 1'b0, '0},  // several dark runs
    '{8'h24, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0}
  };

  line_sensor_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sensors_i   (sensors_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .lost_line_o (lost_line_o),
    .corner_o    (corner_o),
    .fork_type_o (fork_type_o),
    .fork120_o   (fork120_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Classify one sensor vector as a fork candidate
  function automatic fork_e classify_fork(input logic [NumSensors-1:0] s);
    int runs = 0;
    int longest = 0;
    int cur = 0;
    int low_lit;
    int high_lit;
    for (int i = 0; i < NumSensors; i++) begin
      if (!s[i]) begin
        cur++;
      end else if (cur > 0) begin
        runs++;
        if (cur > longest) longest = cur;
        cur = 0;
      end
    end
    if (cur > 0) begin
      runs++;
      if (cur > longest) longest = cur;
    end
    if (!(runs >= 2 || longest >= int'(cfg_gap))) return ForkNone;
    low_lit  = $countones(s[2:0]);
    high_lit = $countones(s[7:5]);
    if (low_lit > high_lit) return ForkLeft;
    if (high_lit > low_lit) return ForkRight;
    return ForkCross;
  endfunction

  // Count consecutive equal candidates; report and clear once confirmed
  function automatic fork_e settle_fork(input fork_e kind);
    if (kind == ForkNone) begin
      fork_cand   = ForkNone;
      fork_stable = 2'd0;
      return ForkNone;
    end
    if (kind == fork_cand) begin
      if (fork_stable < 2'd3) fork_stable++;
    end else begin
      fork_cand   = kind;
      fork_stable = 2'd1;
    end
    if (fork_stable >= cfg_confirm) begin
      fork_cand   = ForkNone;
      fork_stable = 2'd0;
      return kind;
    end
    return ForkNone;
  endfunction

  // Advance the tracker model by one sensor item
  function automatic track_out_t track_sensors(input logic [NumSensors-1:0] s);
    track_out_t r;
    int sum = 0;
    int cnt = 0;
    int segs = 0;
    int filt;
    for (int i = 0; i < NumSensors; i++) begin
      if (s[i]) begin
        sum += int'(SensorWeight[i]);
        cnt++;
      end
    end
    for (int k = HistDepth - 1; k > 0; k--) hist[k] = hist[k-1];
    if (cnt == 0) begin
      r.lost = 1'b1;
      if (last_seen != 0) hist[0] = last_seen;
      else hist[0] = pos_t'((int'(hist[1]) + int'(hist[2]) + int'(hist[3]) +
                             int'(hist[4])) / 4);
    end else begin
      r.lost    = 1'b0;
      hist[0]   = pos_t'(sum / cnt);
      last_seen = hist[0];
    end
    filt = (7 * int'(hist[0]) + 3 * int'(hist[1])) / 10;
    r.position = pos_t'(filt);
    if (&s[7:5]) r.corner = CornerLeft;
    else if (&s[2:0]) r.corner = CornerRight;
    else r.corner = CornerStraight;
    r.fork_kind = settle_fork(classify_fork(s));
    for (int i = 0; i < NumSensors; i++) begin
      if (s[i] && (i == 0 || !s[i-1])) segs++;
    end
    r.fork120 = (segs >= 2 && s[4:3] == 2'b00 && s[2:0] != 3'b000 && s[7:5] != 3'b000);
    return r;
  endfunction

  function automatic logic [NumSensors-1:0] gen_pattern(input pattern_e cls);
    int w;
    int st;
    case (cls)
      PatSegment: begin
        w  = $urandom_range(1, 3);
        st = $urandom_range(0, NumSensors - w);
        return 8'(((1 << w) - 1) << st);
      end
      PatTwoSided: begin
        return 8'($urandom_range(1, 7)) | (8'($urandom_range(1, 7)) << 5) |
               (($urandom_range(0, 3) == 0) ? (8'($urandom_range(1, 3)) << 3) : 8'h00);
      end
      PatExtreme: begin
        return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MaxPrinted)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Write one register over the APB port and mirror it in the model
  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegConfirm) cfg_confirm = ConfirmW'(value);
    else cfg_gap = GapW'(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item, hold it until taken, then queue its expected result
  task automatic send_sensors(input logic [NumSensors-1:0] s, input logic typed,
                              input track_out_t want);
    track_out_t pred;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sensors_i  <= s;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pred = track_sensors(s);
    expected_q.push_back(typed ? want : pred);
  endtask

  // Random bursts: repeats of one pattern class so fork confirmation is reached
  task automatic run_random(input int count);
    int sent = 0;
    int reps;
    int pick;
    pattern_e cls;
    logic [NumSensors-1:0] p;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) cls = PatSegment;
      else if (pick < 65) cls = PatTwoSided;
      else if (pick < 75) cls = PatExtreme;
      else cls = PatNoise;
      p    = gen_pattern(cls);
      reps = $urandom_range(1, 4);
      for (int r = 0; r < reps && sent < count; r++) begin
        if ($urandom_range(0, 3) == 0) p = gen_pattern(cls);
        send_sensors(p, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req) begin
      hold_req    <= 1'b0;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 17);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no pending item", 0, 0);
      end else begin
        want_r = expected_q.pop_front();
        if (position_o !== want_r.position)
          report_mismatch("position", int'(position_o), int'(want_r.position));
        if (lost_line_o !== want_r.lost)
          report_mismatch("lost_line", int'(lost_line_o), int'(want_r.lost));
        if (corner_o !== want_r.corner)
          report_mismatch("corner", int'(corner_o), int'(want_r.corner));
        if (fork_type_o !== want_r.fork_kind)
          report_mismatch("fork_type", int'(fork_type_o), int'(want_r.fork_kind));
        if (fork120_o !== want_r.fork120)
          report_mismatch("fork120", int'(fork120_o), int'(want_r.fork120));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("FAIL line_sensor_tracker_top");
        $finish;
      end
    end
  end

  initial begin
    int unsigned cf;
    int unsigned gp;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sensors_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    for (int k = 0; k < HistDepth; k++) hist[k] = '0;
    last_seen   = '0;
    fork_cand   = ForkNone;
    fork_stable = 2'd0;
    cfg_confirm = ConfirmReset;
    cfg_gap     = GapReset;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under reset values, then random items
    for (int i = 0; i < NumDirected; i++)
      send_sensors(dir_rows[i].sensors, dir_rows[i].typed, dir_rows[i].want);
    run_random(RandPerPhase);
    drain_results();

    // Fixed extreme settings first, then random ones
    for (int ph = 1; ph < NumPhases; ph++) begin
      if (ph <= 5) begin
        cf = phase_confirm[ph-1];
        gp = phase_gap[ph-1];
      end else begin
        cf = $urandom_range(0, 3);
        gp = $urandom_range(0, 15);
      end
      write_reg(RegConfirm, cf);
      write_reg(RegGapMin, gp);
      quiet = (ph == 2);
      if (ph == 3) hold_req = 1'b1;
      run_random(RandPerPhase);
      drain_results();
    end
    quiet = 1'b0;

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS line_sensor_tracker_top");
    end else begin
      $display("FAIL line_sensor_tracker_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lst_pkg.sv
hw/rtl/lst_div.sv
hw/rtl/lst_cfg.sv
hw/rtl/lst_datapath.sv
hw/rtl/lst_ctrl.sv
hw/rtl/line_sensor_tracker_top.sv
hw/rtl/lst_checker.sv
sim/tb_line_sensor_tracker_top.sv
